[rtl/core/cbs_pkg.sv]
`default_nettype none

package cbs_pkg;

    localparam int CELL_COUNT_DEF = 16;
    localparam int ADDR_W         = 4;
    localparam int VOLT_W         = 16;
    localparam int CUR_W          = 16;
    localparam int MASK_W         = 16;
    localparam int PHASE_W        = 10;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 16;

    // item opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_V_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CUR_THR    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_LEN  = 2'd3;

    // configuration reset values
    localparam logic [VOLT_W-1:0]  MAX_V_THR_RST = 16'd3900;
    localparam logic [VOLT_W-1:0]  DIFF_THR_RST  = 16'd30;
    localparam logic [CUR_W-1:0]   CUR_THR_RST   = 16'd0;
    localparam logic [PHASE_W-1:0] PHASE_LEN_RST = 10'd120;

    typedef struct packed {
        logic                     op;
        logic [ADDR_W-1:0]        cell_index;
        logic [VOLT_W-1:0]        load_mv;
        logic                     fe_down;
        logic                     charge_or_standby;
        logic [VOLT_W-1:0]        high_mv;
        logic [VOLT_W-1:0]        low_mv;
        logic [VOLT_W-1:0]        spread_mv;
        logic signed [CUR_W-1:0]  bus_current;
    } in_item_t;

    typedef struct packed {
        logic [MASK_W-1:0] balance_mask;
        logic              balancing_on;
    } out_item_t;

    // scan start request from the scheduler
    typedef struct packed {
        logic              start;
        logic              odd;
        logic [VOLT_W:0]   limit;
    } scan_req_t;

    // scan status back to the scheduler
    typedef struct packed {
        logic busy;
        logic done;
    } scan_stat_t;

    // cell memory read request
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } rd_req_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

endpackage

`default_nettype wire

[rtl/core/cbs_cell_mem.sv]
`default_nettype none

module cbs_cell_mem #(
    parameter int CELL_COUNT = cbs_pkg::CELL_COUNT_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           wr_en,
    input  wire logic [cbs_pkg::ADDR_W-1:0]     wr_addr,
    input  wire logic [cbs_pkg::VOLT_W-1:0]     wr_data,
    input  wire cbs_pkg::rd_req_t               rd,
    output logic [cbs_pkg::VOLT_W-1:0]          rd_data
);

    localparam int IDX_W = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

    logic [cbs_pkg::VOLT_W-1:0] cell_mem [CELL_COUNT];
    logic [cbs_pkg::VOLT_W-1:0] rd_data_reg;

    // loads and scans never overlap, so no write-to-read forwarding
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cell_mem[wr_addr[IDX_W-1:0]] <= wr_data;
        end
        if (rd.en)
        begin
            rd_data_reg <= cell_mem[rd.addr[IDX_W-1:0]];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/core/cbs_mask_scan.sv]
`default_nettype none

module cbs_mask_scan #(
    parameter int CELL_COUNT = cbs_pkg::CELL_COUNT_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire cbs_pkg::scan_req_t             req,
    output cbs_pkg::rd_req_t                    rd,
    input  wire logic [cbs_pkg::VOLT_W-1:0]     rd_data,
    output cbs_pkg::scan_stat_t                 stat,
    output logic [cbs_pkg::MASK_W-1:0]          mask
);

    localparam int CNT_W = $clog2(CELL_COUNT + 2);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic                           pend_reg, pend_next;
    logic [CNT_W-1:0]               rd_idx_reg, rd_idx_next;
    logic [cbs_pkg::ADDR_W-1:0]     pend_idx_reg, pend_idx_next;
    logic [cbs_pkg::MASK_W-1:0]     mask_reg, mask_next;
    logic [cbs_pkg::VOLT_W:0]       limit_reg, limit_next;
    logic                           issue;

    // one read per cell of the selected parity, stepping by two
    assign issue   = busy_reg && (rd_idx_reg < CNT_W'(CELL_COUNT));
    assign rd.en   = issue;
    assign rd.addr = cbs_pkg::ADDR_W'(rd_idx_reg);

    always_comb
    begin
        busy_next     = busy_reg;
        done_next     = 1'b0;
        pend_next     = issue;
        rd_idx_next   = rd_idx_reg;
        pend_idx_next = rd.addr;
        mask_next     = mask_reg;
        limit_next    = limit_reg;

        if (issue)
        begin
            rd_idx_next = rd_idx_reg + CNT_W'(2);
        end

        // compare the cell that came back this cycle
        if (pend_reg && ({1'b0, rd_data} >= limit_reg))
        begin
            mask_next = mask_reg | (cbs_pkg::MASK_W'(1) << pend_idx_reg);
        end

        if (busy_reg && !issue && !pend_reg)
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end

        if (req.start)
        begin
            busy_next   = 1'b1;
            pend_next   = 1'b0;
            rd_idx_next = CNT_W'(req.odd);
            mask_next   = '0;
            limit_next  = req.limit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg   <= rd_idx_next;
        pend_idx_reg <= pend_idx_next;
        mask_reg     <= mask_next;
        limit_reg    <= limit_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign mask      = mask_reg;

endmodule

`default_nettype wire

[rtl/core/cell_balancing_scheduler_unit.sv]
`default_nettype none

// load transfer: the cell voltage is written into the cell memory at accept
// tick with zero mask (off phase, thresholds missed, not charging): result registered in the cycle after accept
// on-phase tick: the result follows the scan, one cell memory read per cell
// of the active parity; next item taken once back in idle with the output register free
// reset: thresholds 3900 / 30 mV and current 0, phase length 120, counters and phase flags cleared
// cell memory contents are not reset; every cell is to be loaded before the first tick

module cell_balancing_scheduler_unit #(
    parameter int CELL_COUNT = cbs_pkg::CELL_COUNT_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire cbs_pkg::in_item_t                  in_item,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output cbs_pkg::out_item_t                      out_item,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [cbs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [cbs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // configuration registers
    logic [cbs_pkg::VOLT_W-1:0]         max_v_thr_reg;
    logic [cbs_pkg::VOLT_W-1:0]         diff_thr_reg;
    logic [cbs_pkg::CUR_W-1:0]          cur_thr_reg;
    logic [cbs_pkg::PHASE_W-1:0]        phase_len_reg;

    // scheduler state
    cbs_pkg::state_t                    state_reg, state_next;
    logic [cbs_pkg::PHASE_W-1:0]        on_ticks_reg, on_ticks_next;
    logic [cbs_pkg::PHASE_W-1:0]        off_ticks_reg, off_ticks_next;
    logic                               in_off_phase_reg, in_off_phase_next;
    logic                               odd_parity_reg, odd_parity_next;

    // output register
    logic                               out_valid_reg, out_valid_next;
    cbs_pkg::out_item_t                 out_item_reg, out_item_next;

    logic                               in_xfer;
    logic                               cfg_xfer;
    logic                               out_free;
    logic                               load_wr;
    logic                               tick_live;
    logic                               thr_ok;
    logic                               start_scan;
    logic [cbs_pkg::PHASE_W-1:0]        on_inc;
    logic [cbs_pkg::PHASE_W-1:0]        off_inc;

    cbs_pkg::scan_req_t                 scan_req;
    cbs_pkg::scan_stat_t                scan_stat;
    cbs_pkg::rd_req_t                   mem_rd;
    logic [cbs_pkg::VOLT_W-1:0]         mem_rd_data;
    logic [cbs_pkg::MASK_W-1:0]         scan_mask;

    // output register can take a new result this cycle
    assign out_free = !out_valid_reg || !out_stall;

    // one item in flight; every item, load or tick, needs room in the output register
    assign in_stall  = (state_reg != cbs_pkg::ST_IDLE) || !out_free;
    assign in_xfer   = in_valid && !in_stall;

    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    // loads beyond the last cell are dropped
    assign load_wr = in_xfer && (in_item.op == cbs_pkg::OP_LOAD)
                  && ({1'b0, in_item.cell_index} < (cbs_pkg::ADDR_W + 1)'(CELL_COUNT));

    // a shutdown tick is swallowed with no result and no state change
    assign tick_live = in_xfer && (in_item.op == cbs_pkg::OP_TICK) && !in_item.fe_down;

    assign thr_ok = (in_item.high_mv > max_v_thr_reg)
                 && (in_item.spread_mv > diff_thr_reg)
                 && ($signed(in_item.bus_current) > $signed(cur_thr_reg));

    // on-phase tick: walk the cell memory for the mask
    assign start_scan = tick_live && in_item.charge_or_standby && thr_ok && !in_off_phase_reg;

    assign on_inc  = on_ticks_reg + cbs_pkg::PHASE_W'(1);
    assign off_inc = off_ticks_reg + cbs_pkg::PHASE_W'(1);

    // the scan uses the parity in force before this tick's toggle
    assign scan_req.start = start_scan;
    assign scan_req.odd   = odd_parity_reg;
    assign scan_req.limit = {1'b0, in_item.low_mv} + {1'b0, diff_thr_reg};

    // phase counters, updated when the tick is taken
    always_comb
    begin
        on_ticks_next     = on_ticks_reg;
        off_ticks_next    = off_ticks_reg;
        in_off_phase_next = in_off_phase_reg;
        odd_parity_next   = odd_parity_reg;

        if (tick_live)
        begin
            if (!in_item.charge_or_standby)
            begin
                on_ticks_next = '0;
            end
            else if (thr_ok)
            begin
                if (!in_off_phase_reg)
                begin
                    if (on_inc == phase_len_reg)
                    begin
                        // end of on phase: rest, then the other parity
                        on_ticks_next     = '0;
                        in_off_phase_next = 1'b1;
                        odd_parity_next   = !odd_parity_reg;
                    end
                    else
                    begin
                        on_ticks_next = on_inc;
                    end
                end
                else
                begin
                    if (off_inc == phase_len_reg)
                    begin
                        off_ticks_next    = '0;
                        in_off_phase_next = 1'b0;
                    end
                    else
                    begin
                        off_ticks_next = off_inc;
                    end
                end
            end
        end
    end

    // sequencer: idle, scan running, result waiting for the output register
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cbs_pkg::ST_IDLE:
            begin
                if (start_scan)
                begin
                    state_next = cbs_pkg::ST_SCAN;
                end
            end
            cbs_pkg::ST_SCAN:
            begin
                if (scan_stat.done)
                begin
                    state_next = cbs_pkg::ST_EMIT;
                end
            end
            cbs_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = cbs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cbs_pkg::ST_IDLE;
            end
        endcase
    end

    // output register: zero-mask ticks load directly, scanned masks from the emit state
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_item_next  = out_item_reg;

        if (tick_live && !start_scan)
        begin
            out_valid_next              = 1'b1;
            out_item_next.balance_mask  = '0;
            out_item_next.balancing_on  = 1'b0;
        end
        else if ((state_reg == cbs_pkg::ST_EMIT) && out_free)
        begin
            out_valid_next              = 1'b1;
            out_item_next.balance_mask  = scan_mask;
            out_item_next.balancing_on  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_v_thr_reg    <= cbs_pkg::MAX_V_THR_RST;
            diff_thr_reg     <= cbs_pkg::DIFF_THR_RST;
            cur_thr_reg      <= cbs_pkg::CUR_THR_RST;
            phase_len_reg    <= cbs_pkg::PHASE_LEN_RST;
            state_reg        <= cbs_pkg::ST_IDLE;
            on_ticks_reg     <= '0;
            off_ticks_reg    <= '0;
            in_off_phase_reg <= 1'b0;
            odd_parity_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_xfer)
            begin
                case (cfg_index)
                    cbs_pkg::CFG_MAX_V_THR: max_v_thr_reg <= cfg_data;
                    cbs_pkg::CFG_DIFF_THR:  diff_thr_reg  <= cfg_data;
                    cbs_pkg::CFG_CUR_THR:   cur_thr_reg   <= cfg_data;
                    cbs_pkg::CFG_PHASE_LEN: phase_len_reg <= cfg_data[cbs_pkg::PHASE_W-1:0];
                    default:                ;
                endcase
            end
            state_reg        <= state_next;
            on_ticks_reg     <= on_ticks_next;
            off_ticks_reg    <= off_ticks_next;
            in_off_phase_reg <= in_off_phase_next;
            odd_parity_reg   <= odd_parity_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // per-cell voltage store
    cbs_cell_mem #(
        .CELL_COUNT (CELL_COUNT)
    ) u_cell_mem (
        .clk     (clk),
        .wr_en   (load_wr),
        .wr_addr (in_item.cell_index),
        .wr_data (in_item.load_mv),
        .rd      (mem_rd),
        .rd_data (mem_rd_data)
    );

    // parity scan that builds the bleed mask
    cbs_mask_scan #(
        .CELL_COUNT (CELL_COUNT)
    ) u_mask_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (scan_req),
        .rd      (mem_rd),
        .rd_data (mem_rd_data),
        .stat    (scan_stat),
        .mask    (scan_mask)
    );

`ifndef SYNTHESIS
    // an inactive result never carries a bleed bit
    a_idle_mask_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_item_reg.balancing_on || (out_item_reg.balance_mask == '0)))
        else $error("bleed bits set on an inactive result");

    // a mask never mixes odd and even cells
    a_single_parity: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (((out_item_reg.balance_mask & 16'h5555) == '0)
                        || ((out_item_reg.balance_mask & 16'hAAAA) == '0)))
        else $error("mask mixes both parities");

    // no bleed bit for a cell that does not exist
    a_mask_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_item_reg.balance_mask >> CELL_COUNT) == '0))
        else $error("mask bit beyond the last cell");

    // the on counter stays cleared through the off phase
    a_off_phase_on_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_off_phase_reg |-> (on_ticks_reg == '0))
        else $error("on counter running in off phase");

    // the scanner only runs while the sequencer waits on it
    a_scan_owned: assert property (@(posedge clk) disable iff (!rst_n)
        scan_stat.busy |-> (state_reg == cbs_pkg::ST_SCAN))
        else $error("scan running outside the scan state");
`endif

endmodule

`default_nettype wire

[tb/cell_balancing_scheduler_unit_tb.sv]
`timescale 1ns / 1ps

module cell_balancing_scheduler_unit_tb;

    localparam int CELLS        = cbs_pkg::CELL_COUNT_DEF;
    localparam int RAND_ITEMS   = 1000;   // counted items in the random part
    localparam int RAND_PHASES  = 10;     // register settings in the random part
    localparam int DRAIN_CYCLES = 32;     // quiet clocks after the owed results have arrived
    localparam int DRAIN_LIMIT  = 5000;
    localparam int MAX_PRINTS   = 40;

    logic                  clk = 1'b0;
    logic                  rst_n;

    // item channel into the block
    logic                  in_valid;
    logic                  in_stall;
    cbs_pkg::in_item_t     in_item;

    // result channel out of the block
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    cbs_pkg::out_item_t    out_item;

    // register write channel
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [cbs_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [cbs_pkg::CFG_DATA_W-1:0]     cfg_data;

    // scheduler mirror: stored cells, counters, phase and parity
    logic [cbs_pkg::VOLT_W-1:0]         cell_mv [CELLS];
    logic [cbs_pkg::PHASE_W-1:0]        on_cnt;
    logic [cbs_pkg::PHASE_W-1:0]        off_cnt;
    logic                               off_phase;
    logic                               odd_sel;

    // register mirror
    logic [cbs_pkg::VOLT_W-1:0]         thr_max;
    logic [cbs_pkg::VOLT_W-1:0]         thr_diff;
    logic signed [cbs_pkg::CUR_W-1:0]   thr_cur;
    logic [cbs_pkg::PHASE_W-1:0]        phase_len;

    // bleed masks still owed by the block, oldest first
    cbs_pkg::out_item_t      pending_masks[$];

    int  err_cnt       = 0;
    int  items_sent    = 0;
    int  results_seen  = 0;
    int  bleed_ticks   = 0;
    int  parity_flips  = 0;
    int  settings_cnt  = 0;
    int  stall_left    = 0;
    bit  idle_on       = 1'b1;

    always #5 clk = ~clk;

    cell_balancing_scheduler_unit #(
        .CELL_COUNT (CELLS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // one line per mismatch, printing capped, counting not
    task automatic report_mismatch(input string what);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS)
        begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // mirror of the scheduler: loads fill the store, live ticks owe one result
    task automatic predict_schedule(input cbs_pkg::in_item_t it);
        cbs_pkg::out_item_t           r;
        logic [cbs_pkg::VOLT_W:0]     limit;
        r = '0;
        if (it.op == cbs_pkg::OP_LOAD)
        begin
            if (int'(it.cell_index) < CELLS)
            begin
                cell_mv[it.cell_index] = it.load_mv;
            end
            return;
        end
        // front end down: nothing moves, nothing comes out
        if (it.fe_down)
        begin
            return;
        end
        if (!it.charge_or_standby)
        begin
            on_cnt = '0;
        end
        else if (it.high_mv > thr_max && it.spread_mv > thr_diff &&
                 $signed(it.bus_current) > thr_cur)
        begin
            if (!off_phase)
            begin
                // margin compare at 17 bits so min plus margin cannot wrap
                limit = {1'b0, it.low_mv} + {1'b0, thr_diff};
                for (int i = int'(odd_sel); i < CELLS; i += 2)
                begin
                    if ({1'b0, cell_mv[cbs_pkg::ADDR_W'(i)]} >= limit)
                    begin
                        r.balance_mask[cbs_pkg::ADDR_W'(i)] = 1'b1;
                    end
                end
                r.balancing_on = 1'b1;
                bleed_ticks++;
                // 10-bit counter, wraps 1023 to 0 before the compare
                on_cnt = on_cnt + 1'b1;
                if (on_cnt == phase_len)
                begin
                    on_cnt    = '0;
                    off_phase = 1'b1;
                    odd_sel   = ~odd_sel;
                    parity_flips++;
                end
            end
            else
            begin
                off_cnt = off_cnt + 1'b1;
                if (off_cnt == phase_len)
                begin
                    off_cnt   = '0;
                    off_phase = 1'b0;
                end
            end
        end
        pending_masks.push_back(r);
    endtask

    // one item transfer; valid stays high when the next item follows with no gap
    task automatic send_item(input cbs_pkg::in_item_t it);
        int gap;
        gap = idle_on ? int'($urandom_range(0, 9)) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_schedule(it);
        items_sent++;
    endtask

    // quiet the item channel, let owed results arrive, then cover silent work
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_masks.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register write transfer; valid is left high for a following write
    task automatic write_reg(input logic [cbs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cbs_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            cbs_pkg::CFG_MAX_V_THR: thr_max   = data;
            cbs_pkg::CFG_DIFF_THR:  thr_diff  = data;
            cbs_pkg::CFG_CUR_THR:   thr_cur   = data;
            cbs_pkg::CFG_PHASE_LEN: phase_len = data[cbs_pkg::PHASE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [cbs_pkg::VOLT_W-1:0] mv,
                                  input logic [cbs_pkg::VOLT_W-1:0] dv,
                                  input logic signed [cbs_pkg::CUR_W-1:0] cv,
                                  input logic [cbs_pkg::PHASE_W-1:0] pl);
        wait_idle();
        write_reg(cbs_pkg::CFG_MAX_V_THR, mv);
        write_reg(cbs_pkg::CFG_DIFF_THR, dv);
        write_reg(cbs_pkg::CFG_CUR_THR, cv);
        write_reg(cbs_pkg::CFG_PHASE_LEN,
                  {{(cbs_pkg::CFG_DATA_W-cbs_pkg::PHASE_W){1'b0}}, pl});
        cfg_valid <= 1'b0;
        settings_cnt++;
    endtask

    // every field random, callers override what matters
    function automatic cbs_pkg::in_item_t rand_fields();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(cbs_pkg::in_item_t)-1:0];
    endfunction

    function automatic cbs_pkg::in_item_t load_item(input int idx,
                                                    input logic [cbs_pkg::VOLT_W-1:0] v);
        cbs_pkg::in_item_t it;
        it            = rand_fields();
        it.op         = cbs_pkg::OP_LOAD;
        it.cell_index = idx[cbs_pkg::ADDR_W-1:0];
        it.load_mv    = v;
        return it;
    endfunction

    function automatic cbs_pkg::in_item_t tick_item(input logic sd, input logic chg,
                                                    input logic [cbs_pkg::VOLT_W-1:0] mx,
                                                    input logic [cbs_pkg::VOLT_W-1:0] mn,
                                                    input logic [cbs_pkg::VOLT_W-1:0] df,
                                                    input logic [cbs_pkg::CUR_W-1:0] cur);
        cbs_pkg::in_item_t it;
        it                   = rand_fields();
        it.op                = cbs_pkg::OP_TICK;
        it.fe_down           = sd;
        it.charge_or_standby = chg;
        it.high_mv           = mx;
        it.low_mv            = mn;
        it.spread_mv         = df;
        it.bus_current       = cur;
        return it;
    endfunction

    // tick that meets every threshold if the settings allow it at all
    function automatic cbs_pkg::in_item_t good_tick();
        cbs_pkg::in_item_t it;
        int                lvl;
        int                lo;
        it                   = rand_fields();
        it.op                = cbs_pkg::OP_TICK;
        it.fe_down           = 1'b0;
        it.charge_or_standby = 1'b1;
        if (thr_max != 16'hFFFF)
        begin
            it.high_mv = 16'($urandom_range(65535, int'(thr_max) + 1));
        end
        if (thr_diff != 16'hFFFF)
        begin
            it.spread_mv = 16'($urandom_range(65535, int'(thr_diff) + 1));
        end
        if (thr_cur != 16'sh7FFF)
        begin
            lo  = int'(thr_cur) + 1;
            lvl = lo + int'($urandom_range(0, 32767 - lo));
            it.bus_current = lvl[cbs_pkg::CUR_W-1:0];
        end
        // min just around a stored cell minus the margin so masks come out mixed
        if ($urandom_range(0, 7) != 0)
        begin
            lvl = int'(cell_mv[cbs_pkg::ADDR_W'($urandom_range(0, CELLS - 1))])
                  - int'(thr_diff) + int'($urandom_range(0, 4)) - 2;
            if (lvl < 0)
            begin
                lvl = 0;
            end
            if (lvl > 65535)
            begin
                lvl = 65535;
            end
            it.low_mv = lvl[cbs_pkg::VOLT_W-1:0];
        end
        return it;
    endfunction

    // result side: check each result transfer, then draw a stall for the next one
    always @(posedge clk)
    begin : result_check
        cbs_pkg::out_item_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (pending_masks.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result, mask %h on %b",
                                              out_item.balance_mask, out_item.balancing_on));
                end
                else
                begin
                    want = pending_masks.pop_front();
                    if (out_item.balance_mask !== want.balance_mask)
                    begin
                        report_mismatch($sformatf("balance_mask %h, want %h",
                                                  out_item.balance_mask, want.balance_mask));
                    end
                    if (out_item.balancing_on !== want.balancing_on)
                    begin
                        report_mismatch($sformatf("balancing_on %b, want %b",
                                                  out_item.balancing_on, want.balancing_on));
                    end
                end
                stall_left = idle_on ? int'($urandom_range(0, 9)) : 0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            out_stall <= (stall_left > 0);
        end
    end

    // load every cell before any tick, store extremes at both ends of the index range
    task automatic test_cell_loads();
        for (int i = 0; i < CELLS; i++)
        begin
            if (i == 0)
            begin
                send_item(load_item(i, 16'h0000));
            end
            else if (i == CELLS - 1)
            begin
                send_item(load_item(i, 16'hFFFF));
            end
            else
            begin
                send_item(load_item(i, 16'(3600 + 40 * i)));
            end
        end
    endtask

    // reset settings 3900 / 30 / 0 / 120, then phase length 1
    task automatic test_tick_cases();
        // shutdown: no result, no state change
        send_item(tick_item(1'b1, 1'b1, 16'hFFFF, 16'd3600, 16'hFFFF, 16'h7FFF));
        // not charging or standby: zero mask, on counter cleared
        send_item(tick_item(1'b0, 1'b0, 16'd4000, 16'd3600, 16'd100, 16'd100));
        // each threshold exactly met but not exceeded, then current at its minimum: zero mask, counters hold
        send_item(tick_item(1'b0, 1'b1, 16'd3900, 16'd3600, 16'd100, 16'd100));
        send_item(tick_item(1'b0, 1'b1, 16'd4000, 16'd3600, 16'd30, 16'd100));
        send_item(tick_item(1'b0, 1'b1, 16'd4000, 16'd3600, 16'd100, 16'd0));
        send_item(tick_item(1'b0, 1'b1, 16'd4000, 16'd3600, 16'd100, 16'h8000));
        // live even tick with mixed mask
        send_item(tick_item(1'b0, 1'b1, 16'd4000, 16'd3600, 16'd100, 16'd1));
        // min at top: margin sum passes 16 bits, nothing bleeds
        send_item(tick_item(1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF));
        // min at zero: every even cell but the empty one
        send_item(tick_item(1'b0, 1'b1, 16'd4000, 16'd0, 16'd100, 16'd1));
        // one-tick phases: on ends and flips parity, off tick, then odd cells
        apply_settings(cbs_pkg::MAX_V_THR_RST, cbs_pkg::DIFF_THR_RST, cbs_pkg::CUR_THR_RST,
                       10'd1);
        // not charging clears the on count so the short phase starts fresh
        send_item(tick_item(1'b0, 1'b0, 16'd4000, 16'd3600, 16'd100, 16'd1));
        send_item(tick_item(1'b0, 1'b1, 16'd4000, 16'd3600, 16'd100, 16'd1));
        send_item(tick_item(1'b0, 1'b1, 16'd4000, 16'd3600, 16'd100, 16'd1));
        send_item(tick_item(1'b0, 1'b1, 16'd4000, 16'd3600, 16'd100, 16'd1));
    endtask

    // phase length lowered below the running count: the phase runs on until it is raised
    task automatic test_phase_below_count();
        idle_on = 1'b0;
        apply_settings(16'd0, 16'd0, 16'h8000, 10'd10);
        while (off_phase || on_cnt != '0) send_item(good_tick());
        repeat (5) send_item(good_tick());
        apply_settings(16'd0, 16'd0, 16'h8000, 10'd3);
        repeat (5) send_item(good_tick());
        apply_settings(16'd0, 16'd0, 16'h8000, 10'd12);
        while (!off_phase) send_item(good_tick());
        idle_on = 1'b1;
    endtask

    // mostly live ticks with random content, some loads, some broken ticks
    task automatic run_random_phase(input int n_items);
        cbs_pkg::in_item_t it;
        int                counted;
        int                sel;
        int                lvl;
        counted = 0;
        while (counted < n_items)
        begin
            sel = $urandom_range(0, 99);
            it  = good_tick();
            if (sel < 58)
            begin
                counted++;
            end
            else if (sel < 70)
            begin
                it = load_item($urandom_range(0, CELLS - 1),
                               ($urandom_range(0, 2) != 0) ? 16'($urandom_range(3000, 4200))
                                                           : 16'($urandom));
                counted++;
            end
            else if (sel < 78)
            begin
                it.charge_or_standby = 1'b0;
                counted++;
            end
            else if (sel < 84)
            begin
                // ignored by the block, not counted
                it.fe_down = 1'b1;
            end
            else if (sel < 93)
            begin
                case ($urandom_range(0, 2))
                    0: it.high_mv = 16'($urandom_range(int'(thr_max), 0));
                    1: it.spread_mv = 16'($urandom_range(int'(thr_diff), 0));
                    default:
                    begin
                        lvl = -32768 + int'($urandom_range(0, int'(thr_cur) + 32768));
                        it.bus_current = lvl[cbs_pkg::CUR_W-1:0];
                    end
                endcase
                counted++;
            end
            else
            begin
                it    = rand_fields();
                it.op = cbs_pkg::OP_TICK;
                if (!it.fe_down)
                begin
                    counted++;
                end
            end
            send_item(it);
        end
    endtask

    task automatic test_random_schedule();
        int cur;
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case (p)
                0: apply_settings(16'd0, 16'd0, 16'h8000, 10'd1);
                1: apply_settings(16'hFFFF, 16'hFFFF, 16'h7FFF, 10'd1023);
                2: apply_settings(16'd3000, 16'd10, 16'hFF9C, 10'd1023);
                default:
                begin
                    cur = int'($urandom_range(0, 2000)) - 1000;
                    apply_settings(16'($urandom_range(0, 4200)), 16'($urandom_range(0, 200)),
                                   cur[cbs_pkg::CUR_W-1:0], 10'($urandom_range(1, 6)));
                end
            endcase
            // every third setting runs with no gaps on either side
            idle_on = (p % 3) != 2;
            run_random_phase(RAND_ITEMS / RAND_PHASES);
        end
    endtask

    initial
    begin
        // known values on every input from time zero
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        // mirror starts at the reset settings with cleared counters
        thr_max   = cbs_pkg::MAX_V_THR_RST;
        thr_diff  = cbs_pkg::DIFF_THR_RST;
        thr_cur   = cbs_pkg::CUR_THR_RST;
        phase_len = cbs_pkg::PHASE_LEN_RST;
        on_cnt    = '0;
        off_cnt   = '0;
        off_phase = 1'b0;
        odd_sel   = 1'b0;
        for (int i = 0; i < CELLS; i++)
        begin
            cell_mv[cbs_pkg::ADDR_W'(i)] = '0;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_cell_loads();
        test_tick_cases();
        test_phase_below_count();
        test_random_schedule();

        // drain what is still owed, bounded
        in_valid <= 1'b0;
        for (int c = 0; c < DRAIN_LIMIT && pending_masks.size() != 0; c++) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_masks.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", pending_masks.size()));
        end

        $display("ran %0d item transfers and checked %0d results over %0d register settings",
                 items_sent, results_seen, settings_cnt);
        $display("saw %0d bleed ticks and %0d parity changes, %0d mismatches",
                 bleed_ticks, parity_flips, err_cnt);
        if (err_cnt == 0)
        begin
            $display("cell_balancing_scheduler_unit_tb OK");
        end
        else
        begin
            $display("cell_balancing_scheduler_unit_tb NOT OK");
        end
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("cell_balancing_scheduler_unit_tb NOT OK");
        $finish;
    end

endmodule
